// ----- hdl/masc_pkg.sv -----
// ----------------------------------------------------------------------------
// masc_pkg
// Shared constants for the multi-axis step chase segment generator.
// ----------------------------------------------------------------------------
package masc_pkg;

  // number of axes; fixed by the port list of the top level
  localparam int MASC_AXES = 4;

  // default step position width
  localparam int MASC_POS_BITS = 24;

  // mask applied to every segment's run length (tick count)
  localparam logic [31:0] MASC_RUN_SPLIT = 32'h0fff_ffff;

endpackage

// ----- hdl/multi_axis_step_chase_segments.sv -----
// ----------------------------------------------------------------------------
// multi_axis_step_chase_segments
// Turns a start/target step position pair per axis into run-length motion
// segments (step mask, direction mask, tick count, last flag).
// ----------------------------------------------------------------------------
// Usage:
//   A move request is taken on a rising edge with start high and busy low;
//   start_axisN / target_axisN are sampled at that edge. busy drops at the
//   edge that presents the last segment of the move.
//   Each segment appears on step_mask, dir_mask, tick_count and last for
//   exactly one cycle with strobe high. The receiver cannot stall: it must
//   take every strobed segment. last marks the final segment of a move.
//   A move with no motion yields one segment: masks 0, tick_count 1, last 1.
// Operation:
//   One shared subtractor does all arithmetic under a small sequencer.
//   Distances come from target - start on every axis, and from start - target
//   on each axis not heading up. A scan compares every axis with the covered
//   mark, and each moving axis beyond the first also with the best so far,
//   then emits; each segment is held for one scan and released by the next,
//   and a final empty scan closes the move. The last segment shows in the
//   first cycle with busy low.
// Reset:
//   rst (synchronous, active high) returns the sequencer to idle, drops
//   strobe and discards any move in progress.
// ----------------------------------------------------------------------------
module multi_axis_step_chase_segments
  import masc_pkg::*;
#(
  parameter int POS_BITS = MASC_POS_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [POS_BITS-1:0] start_axis0,
  input  logic signed [POS_BITS-1:0] start_axis1,
  input  logic signed [POS_BITS-1:0] start_axis2,
  input  logic signed [POS_BITS-1:0] start_axis3,
  input  logic signed [POS_BITS-1:0] target_axis0,
  input  logic signed [POS_BITS-1:0] target_axis1,
  input  logic signed [POS_BITS-1:0] target_axis2,
  input  logic signed [POS_BITS-1:0] target_axis3,
  output logic                       strobe,
  output logic [MASC_AXES-1:0]       step_mask,
  output logic [MASC_AXES-1:0]       dir_mask,
  output logic [POS_BITS-1:0]        tick_count,
  output logic                       last
);

  localparam int OPW    = POS_BITS + 1;
  localparam int AXIS_W = (MASC_AXES > 1) ? $clog2(MASC_AXES) : 1;
  localparam logic [AXIS_W-1:0]   AXIS_LAST  = AXIS_W'(MASC_AXES - 1);
  localparam logic [POS_BITS-1:0] SPLIT_MASK = MASC_RUN_SPLIT[POS_BITS-1:0];
  localparam logic [POS_BITS-1:0] ONE_TICK   = POS_BITS'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;  // target - start
  localparam logic [2:0] S_NEG  = 3'd2;  // start - target
  localparam logic [2:0] S_CMPD = 3'd3;  // dist > done ?
  localparam logic [2:0] S_CMPB = 3'd4;  // dist < best ?
  localparam logic [2:0] S_EMIT = 3'd5;  // best - done, present segment

  logic [2:0]          state;
  logic [AXIS_W-1:0]   axis;
  logic [POS_BITS-1:0] start_q  [MASC_AXES];
  logic [POS_BITS-1:0] target_q [MASC_AXES];
  logic [POS_BITS-1:0] dist_q   [MASC_AXES];
  logic [MASC_AXES-1:0] dirs;
  logic [MASC_AXES-1:0] mask_acc;
  logic [POS_BITS-1:0] done_pos;
  logic [POS_BITS-1:0] best;
  logic                found;
  logic                pend_valid;
  logic [MASC_AXES-1:0] pend_mask;
  logic [POS_BITS-1:0] pend_tick;

  // shared subtractor
  logic [OPW-1:0] op_a;
  logic [OPW-1:0] op_b;
  logic [OPW-1:0] diff;
  logic           neg;
  logic           zero;

  logic [POS_BITS-1:0] cur_start;
  logic [POS_BITS-1:0] cur_target;
  logic [POS_BITS-1:0] cur_dist;
  logic [POS_BITS-1:0] run_len;

  assign cur_start  = start_q[axis];
  assign cur_target = target_q[axis];
  assign cur_dist   = dist_q[axis];

  // operand select for the shared unit
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_DIFF: begin
        op_a = {cur_target[POS_BITS-1], cur_target};
        op_b = {cur_start[POS_BITS-1], cur_start};
      end
      S_NEG: begin
        op_a = {cur_start[POS_BITS-1], cur_start};
        op_b = {cur_target[POS_BITS-1], cur_target};
      end
      S_CMPD: begin
        op_a = {1'b0, done_pos};
        op_b = {1'b0, cur_dist};
      end
      S_CMPB: begin
        op_a = {1'b0, cur_dist};
        op_b = {1'b0, best};
      end
      S_EMIT: begin
        op_a = {1'b0, best};
        op_b = {1'b0, done_pos};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign diff    = op_a - op_b;
  assign neg     = diff[OPW-1];
  assign zero    = (diff == '0);
  assign run_len = diff[POS_BITS-1:0] & SPLIT_MASK;

  assign busy = (state != S_IDLE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      axis       <= '0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            axis  <= '0;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (!neg && !zero) begin
            if (axis == AXIS_LAST) begin
              axis       <= '0;
              found      <= 1'b0;
              pend_valid <= 1'b0;
              state      <= S_CMPD;
            end else begin
              axis <= axis + 1'b1;
            end
          end else begin
            state <= S_NEG;
          end
        end
        S_NEG: begin
          if (axis == AXIS_LAST) begin
            axis       <= '0;
            found      <= 1'b0;
            pend_valid <= 1'b0;
            state      <= S_CMPD;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_DIFF;
          end
        end
        S_CMPD: begin
          // neg means the axis is still moving past the current mark
          if (neg && found) begin
            state <= S_CMPB;
          end else begin
            if (neg) begin
              found <= 1'b1;
            end
            if (axis == AXIS_LAST) begin
              state <= S_EMIT;
            end else begin
              axis <= axis + 1'b1;
            end
          end
        end
        S_CMPB: begin
          if (axis == AXIS_LAST) begin
            state <= S_EMIT;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_CMPD;
          end
        end
        S_EMIT: begin
          if (found) begin
            // a further segment exists: release the held one (if any), hold the new
            strobe     <= pend_valid;
            pend_valid <= 1'b1;
            found      <= 1'b0;
            axis       <= '0;
            state      <= S_CMPD;
          end else begin
            // scan came up empty: the held segment (if any) is the last
            strobe <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          start_q[0]  <= start_axis0;
          start_q[1]  <= start_axis1;
          start_q[2]  <= start_axis2;
          start_q[3]  <= start_axis3;
          target_q[0] <= target_axis0;
          target_q[1] <= target_axis1;
          target_q[2] <= target_axis2;
          target_q[3] <= target_axis3;
          dirs        <= '0;
        end
      end
      S_DIFF: begin
        if (!neg && !zero) begin
          dist_q[axis] <= diff[POS_BITS-1:0];
          dirs[axis]   <= 1'b1;
        end
        done_pos <= '0;
        mask_acc <= '0;
      end
      S_NEG: begin
        dist_q[axis] <= diff[POS_BITS-1:0];
        done_pos     <= '0;
        mask_acc     <= '0;
      end
      S_CMPD: begin
        if (neg) begin
          mask_acc[axis] <= 1'b1;
          if (!found) begin
            best <= cur_dist;
          end
        end
      end
      S_CMPB: begin
        if (neg) begin
          best <= cur_dist;
        end
      end
      S_EMIT: begin
        if (found) begin
          step_mask  <= pend_mask;
          dir_mask   <= dirs;
          tick_count <= pend_tick;
          last       <= 1'b0;
          pend_mask  <= mask_acc;
          pend_tick  <= run_len;
          done_pos   <= best;
          mask_acc   <= '0;
        end else if (pend_valid) begin
          step_mask  <= pend_mask;
          dir_mask   <= dirs;
          tick_count <= pend_tick;
          last       <= 1'b1;
        end else begin
          step_mask  <= '0;
          dir_mask   <= '0;
          tick_count <= ONE_TICK;
          last       <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- tb/masc_segment_checker.sv -----
// ----------------------------------------------------------------------------
// masc_segment_checker
// Watches the move request and segment channels of the step chase block,
// predicts the run-length segments of every accepted move and compares each
// strobed segment, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module masc_segment_checker
  import masc_pkg::*;
#(
  parameter int POS_BITS = MASC_POS_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [POS_BITS-1:0] start_axis0,
  input  logic [POS_BITS-1:0] start_axis1,
  input  logic [POS_BITS-1:0] start_axis2,
  input  logic [POS_BITS-1:0] start_axis3,
  input  logic [POS_BITS-1:0] target_axis0,
  input  logic [POS_BITS-1:0] target_axis1,
  input  logic [POS_BITS-1:0] target_axis2,
  input  logic [POS_BITS-1:0] target_axis3,
  input  logic                strobe,
  input  logic [MASC_AXES-1:0] step_mask,
  input  logic [MASC_AXES-1:0] dir_mask,
  input  logic [POS_BITS-1:0] tick_count,
  input  logic                last,
  output int                  bad_segments,
  output int                  segments_due
);

  typedef logic [MASC_AXES-1:0][POS_BITS-1:0] pos_vec_t;

  typedef struct packed {
    logic [MASC_AXES-1:0] steps;
    logic [MASC_AXES-1:0] dirs;
    logic [POS_BITS-1:0]  ticks;
    logic                 fin;
  } segment_t;

  segment_t segment_q[$];
  int       fail_count = 0;

  // chase every axis toward its target; cut a segment at each arrival
  function automatic void plan_segments(input pos_vec_t from, input pos_vec_t to);
    longint               gap [MASC_AXES];
    longint               here;
    longint               there;
    longint               covered;
    longint               nearest;
    logic [MASC_AXES-1:0] heading;
    logic [MASC_AXES-1:0] moving;
    segment_t             seg;
    int                   cut;
    bit                   found;
    heading = '0;
    for (int a = 0; a < MASC_AXES; a++) begin
      here  = $signed(from[a]);
      there = $signed(to[a]);
      if (there > here) begin
        gap[a]     = there - here;
        heading[a] = 1'b1;
      end else begin
        gap[a] = here - there;
      end
    end
    covered = 0;
    cut     = 0;
    while (cut < MASC_AXES) begin
      moving  = '0;
      nearest = 0;
      found   = 1'b0;
      for (int a = 0; a < MASC_AXES; a++) begin
        if (gap[a] > covered) begin
          moving[a] = 1'b1;
          if (!found || gap[a] < nearest) begin
            nearest = gap[a];
            found   = 1'b1;
          end
        end
      end
      if (!found) break;
      seg.steps = moving;
      seg.dirs  = heading;
      seg.ticks = POS_BITS'(nearest - covered);
      seg.fin   = 1'b0;
      segment_q.insert(segment_q.size(), seg);
      covered = nearest;
      cut++;
    end
    // nothing moves: one empty segment of one tick
    if (cut == 0) begin
      seg.steps = '0;
      seg.dirs  = '0;
      seg.ticks = POS_BITS'(1);
      seg.fin   = 1'b1;
      segment_q.insert(segment_q.size(), seg);
    end else begin
      segment_q[segment_q.size()-1].fin = 1'b1;
    end
  endfunction

  function automatic void note_failure(input segment_t want, input bit had_want);
    fail_count++;
    if (fail_count <= 10) begin
      if (!had_want)
        $display("segment with none pending: step %h dir %h ticks %0d last %b",
                 step_mask, dir_mask, tick_count, last);
      else
        $display({"segment mismatch: expected step %h dir %h ticks %0d last %b,",
                  " got step %h dir %h ticks %0d last %b"},
                 want.steps, want.dirs, want.ticks, want.fin,
                 step_mask, dir_mask, tick_count, last);
    end
  endfunction

  // compare strobed segments first, then record a newly taken request
  always @(posedge clk) begin : watch
    segment_t want;
    pos_vec_t from;
    pos_vec_t to;
    if (!rst) begin
      if (strobe) begin
        if (segment_q.size() == 0) begin
          want = '0;
          note_failure(want, 1'b0);
        end else begin
          want = segment_q.pop_front();
          if (want.steps !== step_mask || want.dirs !== dir_mask ||
              want.ticks !== tick_count || want.fin !== last)
            note_failure(want, 1'b1);
        end
      end
      if (start && !busy) begin
        from = {start_axis3, start_axis2, start_axis1, start_axis0};
        to   = {target_axis3, target_axis2, target_axis1, target_axis0};
        plan_segments(from, to);
      end
    end
    segments_due <= segment_q.size();
    bad_segments <= fail_count;
  end

endmodule

// ----- tb/tb_multi_axis_step_chase_segments.sv -----
// ----------------------------------------------------------------------------
// tb_multi_axis_step_chase_segments
// Drives move requests into the step chase block: a directed set of corner
// moves, then random moves, most with shared distances so that axes tie and
// split into several segments. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_multi_axis_step_chase_segments;
  import masc_pkg::*;

  localparam int PB          = MASC_POS_BITS;
  localparam int AX          = MASC_AXES;
  localparam int RAND_MOVES  = 410;
  localparam int TAIL_CYCLES = 64;

  typedef logic [AX-1:0][PB-1:0] pos_vec_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [PB-1:0] start_axis0 = '0;
  logic signed [PB-1:0] start_axis1 = '0;
  logic signed [PB-1:0] start_axis2 = '0;
  logic signed [PB-1:0] start_axis3 = '0;
  logic signed [PB-1:0] target_axis0 = '0;
  logic signed [PB-1:0] target_axis1 = '0;
  logic signed [PB-1:0] target_axis2 = '0;
  logic signed [PB-1:0] target_axis3 = '0;
  logic                 strobe;
  logic [AX-1:0]        step_mask;
  logic [AX-1:0]        dir_mask;
  logic [PB-1:0]        tick_count;
  logic                 last;
  int                   bad_segments;
  int                   segments_due;

  // request pacing
  int burst_left = 0;
  bit req_up     = 1'b0;

  multi_axis_step_chase_segments #(
    .POS_BITS(PB)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .start_axis0 (start_axis0),
    .start_axis1 (start_axis1),
    .start_axis2 (start_axis2),
    .start_axis3 (start_axis3),
    .target_axis0(target_axis0),
    .target_axis1(target_axis1),
    .target_axis2(target_axis2),
    .target_axis3(target_axis3),
    .strobe      (strobe),
    .step_mask   (step_mask),
    .dir_mask    (dir_mask),
    .tick_count  (tick_count),
    .last        (last)
  );

  masc_segment_checker #(
    .POS_BITS(PB)
  ) i_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .start_axis0 (start_axis0),
    .start_axis1 (start_axis1),
    .start_axis2 (start_axis2),
    .start_axis3 (start_axis3),
    .target_axis0(target_axis0),
    .target_axis1(target_axis1),
    .target_axis2(target_axis2),
    .target_axis3(target_axis3),
    .strobe      (strobe),
    .step_mask   (step_mask),
    .dir_mask    (dir_mask),
    .tick_count  (tick_count),
    .last        (last),
    .bad_segments(bad_segments),
    .segments_due(segments_due)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop
  initial begin
    #1_000_000;
    $display("tb_multi_axis_step_chase_segments failed");
    $finish;
  end

  // present one move request and hold it until the block takes it
  task automatic issue_move(input pos_vec_t from, input pos_vec_t to);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(20, 40))
                                               : int'($urandom_range(1, 8));
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = int'($urandom_range(30, 70));
        default: gap = int'($urandom_range(1, 15));
      endcase
      if (gap > 0) begin
        if (req_up) start <= 1'b0;
        req_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start        <= 1'b1;
    req_up        = 1'b1;
    start_axis0  <= from[0];
    start_axis1  <= from[1];
    start_axis2  <= from[2];
    start_axis3  <= from[3];
    target_axis0 <= to[0];
    target_axis1 <= to[1];
    target_axis2 <= to[2];
    target_axis3 <= to[3];
    do @(posedge clk); while (busy);
  endtask

  // stop requesting until every predicted segment has come out
  task automatic settle_moves();
    if (req_up) start <= 1'b0;
    req_up     = 1'b0;
    burst_left = 0;
    do @(posedge clk); while (segments_due != 0);
  endtask

  task automatic aim(input int s0, input int s1, input int s2, input int s3,
                     input int t0, input int t1, input int t2, input int t3);
    pos_vec_t from;
    pos_vec_t to;
    from = {s3[PB-1:0], s2[PB-1:0], s1[PB-1:0], s0[PB-1:0]};
    to   = {t3[PB-1:0], t2[PB-1:0], t1[PB-1:0], t0[PB-1:0]};
    issue_move(from, to);
  endtask

  // random move: distances mostly drawn from a small shared palette so axes tie
  task automatic pick_move(output pos_vec_t from, output pos_vec_t to);
    logic [PB-1:0] palette [AX];
    logic [PB-1:0] base;
    logic [PB-1:0] span;
    int            style;
    style = int'($urandom_range(0, 9));
    for (int p = 0; p < AX; p++) begin
      case ($urandom_range(0, 4))
        0:       palette[p] = '0;
        1:       palette[p] = PB'($urandom_range(1, 16));
        2:       palette[p] = PB'($urandom_range(1, 4000));
        default: palette[p] = PB'($urandom);
      endcase
    end
    for (int a = 0; a < AX; a++) begin
      base = PB'($urandom);
      // positions near the ends of the range
      if (style == 1)
        base = $urandom_range(0, 1) ? PB'(24'h7fffff - $urandom_range(0, 40))
                                    : PB'(24'h800000 + $urandom_range(0, 40));
      if (style == 0) begin
        from[a] = base;
        to[a]   = PB'($urandom);
      end else begin
        span    = palette[$urandom_range(0, AX-1)];
        from[a] = base;
        to[a]   = $urandom_range(0, 1) ? base + span : base - span;
      end
    end
  endtask

  initial begin
    pos_vec_t from;
    pos_vec_t to;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    aim(0, 0, 0, 0, 0, 0, 0, 0);
    aim(5, -7, 8388607, -8388608, 5, -7, 8388607, -8388608);
    aim(-8388608, 0, 0, 0, 8388607, 0, 0, 0);
    aim(0, 8388607, 0, 0, 0, -8388608, 0, 0);
    aim(-8388608, 8388607, -8388608, 8388607, 8388607, -8388608, 8388607, -8388608);
    aim(0, 0, 0, 0, 1, 2, 3, 4);
    aim(0, 0, 0, 0, -4, -3, -2, -1);
    aim(10, 10, 10, 10, 15, 5, 18, 10);
    aim(100, -100, 7, 7, 101, -100, 7, 7);
    aim(1, 2, 3, -3, 1, 2, 3, 9);
    aim(0, 0, 0, 0, 3, -3, 3, -3);
    aim(0, 0, 0, 0, 6, -6, 2, 0);
    aim(8388607, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608, -8388608);
    aim(-1000, 2000, -3000, 4000, 5000, -6000, 7000, -8000);
    aim(0, 0, 0, 0, 1, 1, 1, 1);
    aim(-5, 5, 0, 0, -1, 1, 0, 0);
    aim(20, 20, 20, 20, 20, 25, 25, 30);
    aim(-8388608, -8388608, 0, 0, -8388607, -8388606, 0, 0);
    aim(4660, -22136, 1, -1, 1, 4660, -22136, 2);
    aim(0, 0, 0, 0, 0, 0, 0, 0);
    settle_moves();

    // random moves, with a full pause now and then
    for (int k = 0; k < RAND_MOVES; k++) begin
      if (k % 100 == 50) settle_moves();
      pick_move(from, to);
      issue_move(from, to);
    end
    if (req_up) start <= 1'b0;
    req_up = 1'b0;

    do @(posedge clk); while (segments_due != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_segments == 0 && segments_due == 0) begin
      $display("tb_multi_axis_step_chase_segments passed");
    end else begin
      $display("tb_multi_axis_step_chase_segments failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/masc_pkg.sv
hdl/multi_axis_step_chase_segments.sv
tb/masc_segment_checker.sv
tb/tb_multi_axis_step_chase_segments.sv
